/* design/assert_macros.svh */
// Assertion macros used by the video timing classifier controller.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked at every edge outside reset
`define VTC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m failed");
// condition that must never hold outside reset
`define VTC_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) not (cond)) else $error("%m failed");
`endif

/* design/vtc_pkg.sv */
// Package for the video timing classifier: table, widths, codes.
// No dependencies.
package vtc_pkg;
  localparam int unsigned RomDepth     = 64;
  localparam int unsigned TableEntries = 64;
  localparam int unsigned RateWindow   = 255;

  localparam logic [1:0] StMatched  = 2'd0;
  localparam logic [1:0] StFallback = 2'd1;
  localparam logic [1:0] StNoEntry  = 2'd2;
  localparam logic [1:0] StZeroDiv  = 2'd3;

  // divider operand selects
  localparam logic [1:0] DselClock = 2'd0;
  localparam logic [1:0] DselLine  = 2'd1;
  localparam logic [1:0] DselFrame = 2'd2;

  typedef struct packed {
    logic       load;
    logic       div_start;
    logic [1:0] div_sel;
    logic       scan_clr;
    logic       scan_step;
    logic       finish;
  } vtc_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic scan_last;
    logic zero_div;
  } vtc_sts_t;

  function automatic logic [31:0] row(input int h, input int v, input int i, input int f);
    row = 32'(h) | (32'(v) << 12) | (32'(i) << 23) | (32'(f) << 24);
  endfunction

  function automatic logic [31:0] rom_word(input logic [5:0] a);
    logic [31:0] w;
    w = '0;
    case (a)
      6'd0: w = row(800,525,0,60);    6'd1: w = row(858,525,0,60);
      6'd2: w = row(858,525,0,60);    6'd3: w = row(1650,750,0,60);
      6'd4: w = row(2200,562,1,60);   6'd5: w = row(858,262,1,60);
      6'd6: w = row(858,262,1,60);    6'd7: w = row(858,262,0,60);
      6'd8: w = row(858,262,0,60);    6'd9: w = row(858,262,1,60);
      6'd10: w = row(858,262,1,60);   6'd11: w = row(858,262,0,60);
      6'd12: w = row(858,262,0,60);   6'd13: w = row(1716,525,0,60);
      6'd14: w = row(1716,525,0,60);  6'd15: w = row(2200,1125,0,60);
      6'd16: w = row(864,625,0,50);   6'd17: w = row(864,625,0,50);
      6'd18: w = row(1980,750,0,50);  6'd19: w = row(2640,562,1,50);
      6'd20: w = row(864,312,1,50);   6'd21: w = row(864,312,1,50);
      6'd22: w = row(864,312,0,50);   6'd23: w = row(864,312,0,50);
      6'd24: w = row(864,312,1,50);   6'd25: w = row(864,312,1,50);
      6'd26: w = row(864,312,0,50);   6'd27: w = row(864,312,0,50);
      6'd28: w = row(1728,625,0,50);  6'd29: w = row(1728,625,0,50);
      6'd30: w = row(2640,1125,0,50); 6'd31: w = row(2750,1125,0,24);
      6'd32: w = row(2640,1125,0,25); 6'd33: w = row(2200,1125,0,30);
      6'd34: w = row(3432,525,0,60);  6'd35: w = row(3432,525,0,60);
      6'd36: w = row(3456,625,0,50);  6'd37: w = row(3456,625,0,50);
      6'd38: w = row(2304,625,1,50);  6'd39: w = row(2640,562,1,100);
      6'd40: w = row(1980,750,0,100); 6'd41: w = row(864,625,0,100);
      6'd42: w = row(864,625,0,100);  6'd43: w = row(864,312,1,100);
      6'd44: w = row(864,312,1,100);  6'd45: w = row(2200,562,1,120);
      6'd46: w = row(1650,750,0,120); 6'd47: w = row(858,525,0,120);
      6'd48: w = row(858,525,0,120);  6'd49: w = row(858,262,1,120);
      6'd50: w = row(858,262,1,120);  6'd51: w = row(864,625,0,200);
      6'd52: w = row(864,625,0,200);  6'd53: w = row(864,312,1,200);
      6'd54: w = row(864,312,1,200);  6'd55: w = row(858,525,0,240);
      6'd56: w = row(858,525,0,240);  6'd57: w = row(858,262,1,240);
      6'd58: w = row(858,262,1,240);  6'd59: w = row(3300,750,0,24);
      6'd60: w = row(3960,750,0,25);  6'd61: w = row(3300,750,0,30);
      6'd62: w = row(2200,1125,0,120);
      default: w = row(2640,1125,0,100);
    endcase
    return w;
  endfunction
endpackage

/* design/vtc_div.sv */
// Restoring divider, one quotient bit per cycle, 32-bit dividend.
// Depends on vtc_pkg.
module vtc_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [13:0] divisor_i,
  output logic        busy_o,
  output logic [31:0] quot_o
);
  import vtc_pkg::*;
  logic [31:0] q_q, q_d;
  logic [13:0] r_q, r_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [14:0] sh;
  logic [15:0] diff;

  always_comb begin
    q_d   = q_q;
    r_d   = r_q;
    cnt_d = cnt_q;
    sh    = {r_q, q_q[31]};
    diff  = {1'b0, sh} - {2'b0, divisor_i};
    if (start_i) begin
      q_d   = dividend_i;
      r_d   = '0;
      cnt_d = 6'd32;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 6'd1;
      if (!diff[15]) begin
        r_d = diff[13:0];
        q_d = {q_q[30:0], 1'b1};
      end else begin
        r_d = sh[13:0];
        q_d = {q_q[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
    r_q <= r_d;
  end

  assign busy_o = cnt_q != '0;
  assign quot_o = q_q;
endmodule

/* design/vtc_datapath.sv */
// Datapath: input capture, divider, rate scaling, table scan and result.
// Depends on vtc_pkg and vtc_div.
module vtc_datapath #(
  parameter int unsigned TableEntries = vtc_pkg::TableEntries,
  parameter int unsigned RateWindow   = vtc_pkg::RateWindow
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  vtc_pkg::vtc_cmd_t cmd_i,
  output vtc_pkg::vtc_sts_t sts_o,
  input  logic [71:0]      in_data_i,
  output logic [45:0]      res_o
);
  import vtc_pkg::*;
  localparam int unsigned Rows = (TableEntries < RomDepth) ? TableEntries : RomDepth;

  logic        on_q;
  logic [13:0] ht_q, ha_q;
  logic [11:0] vt_q, va_q;
  logic [7:0]  cnt_q, vic_q;
  logic [1:0]  mode_q;
  logic [31:0] rate_q;
  logic [11:0] pclk_q;
  logic [30:0] pclk_prod;
  logic [31:0] dvd;
  logic [13:0] dvs;
  logic        busy;
  logic [31:0] quot;
  logic [5:0]  idx_q;
  logic [8:0]  best_q;
  logic [5:0]  pick_q;
  logic        found_q;
  logic [31:0] w, pw;
  logic [31:0] rate_diff;
  logic        hit;
  logic [45:0] res_q, res_d;
  logic        fb_ok;
  logic [5:0]  sel;
  logic        unused;

  vtc_div u_div (
    .clk_i, .rst_ni, .start_i(cmd_i.div_start), .dividend_i(dvd), .divisor_i(dvs),
    .busy_o(busy), .quot_o(quot)
  );

  // pclk = (31620 / count) / 10; the divide by ten is a reciprocal multiply,
  // exact for quotients up to 31620
  assign pclk_prod = 31'(quot[14:0]) * 31'd52429;

  always_ff @(posedge clk_i) begin
    pclk_q <= pclk_prod[30:19];
  end

  // pclk <= 3162 so pclk*1e6 fits 32 bits
  always_comb begin
    case (cmd_i.div_sel)
      DselClock: begin dvd = 32'd31620; dvs = {6'd0, cnt_q}; end
      DselLine: begin dvd = {20'd0, pclk_q} * 32'd1000000; dvs = ht_q; end
      default: begin dvd = quot; dvs = {2'd0, vt_q}; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      {vic_q, mode_q, cnt_q, va_q, vt_q, ha_q, ht_q, on_q} <= in_data_i[70:0];
    end
  end

  assign w         = rom_word(idx_q);
  assign rate_diff = (rate_q > {24'd0, w[31:24]}) ? rate_q - {24'd0, w[31:24]}
                                                  : {24'd0, w[31:24]} - rate_q;
  assign hit  = (ht_q == {2'd0, w[11:0]}) &&
                ((vt_q == {1'b0, w[22:12]}) || (vt_q == {1'b0, w[22:12]} + 12'd1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_clr) begin
      idx_q   <= '0;
      best_q  <= 9'(RateWindow);
      found_q <= 1'b0;
      pick_q  <= '0;
      rate_q  <= quot;
    end else if (cmd_i.scan_step) begin
      idx_q <= idx_q + 6'd1;
      if (hit && rate_diff < {23'd0, best_q}) begin
        best_q  <= rate_diff[8:0];
        pick_q  <= idx_q;
        found_q <= 1'b1;
      end
    end
  end

  assign fb_ok = (vic_q != 8'd0) && ({1'b0, vic_q} <= 9'(Rows));
  assign sel   = found_q ? pick_q : 6'(vic_q - 8'd1);
  assign pw    = rom_word(sel);

  always_comb begin
    res_d = '0;
    res_d[43:42] = StNoEntry;
    if (on_q) begin
      res_d[14:1]  = ha_q;
      res_d[26:15] = va_q;
      res_d[45:44] = mode_q;
      if (sts_o.zero_div) begin
        res_d[43:42] = StZeroDiv;
      end else if (found_q || fb_ok) begin
        res_d[43:42] = found_q ? StMatched : StFallback;
        res_d[0]     = 1'b1;
        res_d[34:27] = pw[31:24];
        res_d[35]    = pw[23];
        res_d[41:36] = sel;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;
  assign sts_o.div_busy  = busy;
  assign sts_o.scan_last = idx_q == 6'(Rows - 1);
  assign sts_o.zero_div  = !on_q || cnt_q == '0 || ht_q == '0 || vt_q == '0;
  assign unused = in_data_i[71];
endmodule

/* design/vtc_ctrl.sv */
// Controller: sequences divisions, table scan and result handshake.
// Depends on vtc_pkg and assert_macros.svh.
module vtc_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output vtc_pkg::vtc_cmd_t cmd_o,
  input  vtc_pkg::vtc_sts_t sts_i
);
  import vtc_pkg::*;
  `include "assert_macros.svh"
  localparam logic [2:0] SIdle = 3'd0, SDivGo = 3'd1, SDivWait = 3'd2,
                         SScan = 3'd3, SDone = 3'd4, SOut = 3'd5, SClr = 3'd6;
  logic [2:0] st_q, st_d;
  logic [1:0] sel_q, sel_d;
  logic       ov_q, ov_d;

  always_comb begin
    st_d = st_q; sel_d = sel_q; ov_d = ov_q;
    cmd_o = '0;
    cmd_o.div_sel = sel_q;
    in_ready_o = (st_q == SIdle);
    if (ov_q && out_ready_i) ov_d = 1'b0;
    case (st_q)
      SIdle: if (in_valid_i) begin
        cmd_o.load = 1'b1; st_d = SDivGo; sel_d = DselClock;
      end
      SDivGo: begin
        if (sts_i.zero_div) begin
          st_d = SDone;
        end else begin
          cmd_o.div_start = 1'b1; st_d = SDivWait;
        end
      end
      SDivWait: if (!sts_i.div_busy) begin
        if (sel_q == DselFrame) begin
          st_d = SClr;
        end else begin
          sel_d = sel_q + 2'd1; st_d = SDivGo;
        end
      end
      SClr: begin cmd_o.scan_clr = 1'b1; st_d = SScan; end
      SScan: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_last) st_d = SDone;
      end
      SDone: if (!ov_q) begin cmd_o.finish = 1'b1; st_d = SOut; end
      SOut: begin ov_d = 1'b1; st_d = SIdle; end
      default: st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle; sel_q <= '0; ov_q <= 1'b0;
    end else begin
      st_q <= st_d; sel_q <= sel_d; ov_q <= ov_d;
    end
  end
  assign out_valid_o = ov_q;

  `VTC_ASSERT(a_ld_idle, clk_i, rst_ni, cmd_o.load |-> st_q == SIdle)
  `VTC_ASSERT(a_fin_free, clk_i, rst_ni, cmd_o.finish |-> !ov_q)
  `VTC_ASSERT(a_hold, clk_i, rst_ni, (ov_q && !out_ready_i) |=> ov_q)
  `VTC_NEVER(a_ld_fin, clk_i, rst_ni, cmd_o.load && cmd_o.finish)
endmodule

/* design/video_timing_classifier_unit.sv */
// Video timing classifier top level: controller plus datapath.
// Depends on vtc_pkg, vtc_ctrl, vtc_datapath.
// Per item: three serial divisions, a clear, a scan of the table rows and the
// result registers; video off or a zero divisor skips the divisions and the scan.
// One item at a time, next taken once the result is offered; a held result blocks finish.
// Reset: asynchronous active low, clears controller state and output valid.
module video_timing_classifier_unit #(
  parameter int unsigned TableEntries = vtc_pkg::TableEntries,
  parameter int unsigned RateWindow   = vtc_pkg::RateWindow
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // video_on, line_total, line_active, frame_total, frame_active, clock_count,
  // colour_mode, reported_vic, zero pad
  input  logic [71:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // valid_res, width, height, frame_rate, interlaced, entry_index, status,
  // format_code, zero pad
  output logic [47:0] m_axis_tdata
);
  import vtc_pkg::*;
  vtc_cmd_t cmd;
  vtc_sts_t sts;
  logic [45:0] res;

  vtc_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready), .cmd_o(cmd), .sts_i(sts)
  );
  vtc_datapath #(.TableEntries(TableEntries), .RateWindow(RateWindow)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .in_data_i(s_axis_tdata), .res_o(res)
  );
  assign m_axis_tdata = {2'b0, res};
endmodule

/* test/video_timing_classifier_unit_tb.sv */
// Testbench for video_timing_classifier_unit: stream driver and monitor, with a
// timing-table classifier predictor that checks every result item field by field.
// Depends on vtc_pkg and the video_timing_classifier_unit RTL.
module video_timing_classifier_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 2000000;
  localparam int unsigned RandItems  = 850;

  typedef struct packed {
    logic [7:0]  vic;
    logic [1:0]  mode;
    logic [7:0]  cnt;
    logic [11:0] va;
    logic [11:0] vt;
    logic [13:0] ha;
    logic [13:0] ht;
    logic        on;
  } timing_t;

  typedef struct packed {
    logic [1:0]  fmt;
    logic [1:0]  status;
    logic [5:0]  idx;
    logic        intl;
    logic [7:0]  rate;
    logic [11:0] height;
    logic [13:0] width;
    logic        ok;
  } format_t;

  typedef struct {
    timing_t t;
    bit      drain_first;
  } pend_t;

  // CEA timing rows: htotal, vtotal, interlace, rate
  int cea_h[64] = '{800, 858, 858, 1650, 2200, 858, 858, 858, 858, 858, 858, 858, 858, 1716,
    1716, 2200, 864, 864, 1980, 2640, 864, 864, 864, 864, 864, 864, 864, 864, 1728, 1728, 2640,
    2750, 2640, 2200, 3432, 3432, 3456, 3456, 2304, 2640, 1980, 864, 864, 864, 864, 2200, 1650,
    858, 858, 858, 858, 864, 864, 864, 864, 858, 858, 858, 858, 3300, 3960, 3300, 2200, 2640};
  int cea_v[64] = '{525, 525, 525, 750, 562, 262, 262, 262, 262, 262, 262, 262, 262, 525, 525,
    1125, 625, 625, 750, 562, 312, 312, 312, 312, 312, 312, 312, 312, 625, 625, 1125, 1125,
    1125, 1125, 525, 525, 625, 625, 625, 562, 750, 625, 625, 312, 312, 562, 750, 525, 525, 262,
    262, 625, 625, 312, 312, 525, 525, 262, 262, 750, 750, 750, 1125, 1125};
  int cea_i[64] = '{0, 0, 0, 0, 1, 1, 1, 0, 0, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 1, 0, 0, 1,
    1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 0, 0, 0, 1, 1, 1, 0, 0, 0, 1, 1, 0, 0, 1, 1,
    0, 0, 1, 1, 0, 0, 0, 0, 0};
  int cea_f[64] = '{60, 60, 60, 60, 60, 60, 60, 60, 60, 60, 60, 60, 60, 60, 60, 60, 50, 50, 50,
    50, 50, 50, 50, 50, 50, 50, 50, 50, 50, 50, 50, 24, 25, 30, 60, 60, 50, 50, 50, 100, 100,
    100, 100, 100, 100, 120, 120, 120, 120, 120, 120, 200, 200, 200, 200, 240, 240, 240, 240,
    24, 25, 30, 120, 100};

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // video_on, line_total, line_active, frame_total, frame_active, clock_count,
  // colour_mode, reported_vic, zero pad
  logic [71:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // valid_res, width, height, frame_rate, interlaced, entry_index, status,
  // format_code, zero pad
  logic [47:0] m_axis_tdata;

  pend_t   pending_q[$];
  format_t format_q[$];
  int      n_errors = 0;
  int      n_taken = 0;
  int      n_sent = 0;
  int      n_seen = 0;
  int      n_match = 0;
  int      n_fallback = 0;
  int      n_reject = 0;
  int      cycles = 0;
  bit      feeding = 1'b0;
  bit      stall_done = 1'b0;
  int      in_gap = 0;
  int      out_gap = 0;
  int      long_hold = 0;

  video_timing_classifier_unit u_dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic format_t classify(timing_t t);
    format_t r;
    longint  rate;
    longint  d;
    longint  best;
    int      pick;
    bit      found;
    r = '0;
    r.status = vtc_pkg::StNoEntry;
    best = vtc_pkg::RateWindow;
    pick = 0;
    found = 1'b0;
    if (!t.on) return r;
    r.width = t.ha;
    r.height = t.va;
    r.fmt = t.mode;
    if (t.cnt == 0 || t.ht == 0 || t.vt == 0) begin
      r.status = vtc_pkg::StZeroDiv;
      return r;
    end
    rate = longint'((31620 / int'(t.cnt)) / 10) * 1000000;
    rate = rate / t.ht;
    rate = rate / t.vt;
    for (int i = 0; i < 64; i++) begin
      if (t.ht == cea_h[i] && (t.vt == cea_v[i] || t.vt == cea_v[i] + 1)) begin
        d = rate > cea_f[i] ? rate - cea_f[i] : cea_f[i] - rate;
        if (d < best) begin
          best = d;
          pick = i;
          found = 1'b1;
        end
      end
    end
    if (found) begin
      r.status = vtc_pkg::StMatched;
    end else if (t.vic >= 1 && t.vic <= 64) begin
      pick = int'(t.vic) - 1;
      r.status = vtc_pkg::StFallback;
    end else begin
      return r;
    end
    r.ok = 1'b1;
    r.rate = 8'(cea_f[pick]);
    r.intl = cea_i[pick][0];
    r.idx = 6'(pick);
    return r;
  endfunction

  function automatic timing_t noise_timing();
    timing_t t;
    t = 71'({$urandom, $urandom, $urandom});
    t.on = ($urandom_range(0, 7) != 0);
    return t;
  endfunction

  // a well-formed timing on a table row, vtotal exact or one more
  function automatic timing_t row_timing(int r);
    timing_t t;
    t = noise_timing();
    t.on = 1'b1;
    t.ht = 14'(cea_h[r]);
    t.vt = 12'(cea_v[r] + int'($urandom_range(0, 1)));
    t.cnt = 8'($urandom_range(1, 255));
    return t;
  endfunction

  task automatic queue_item(timing_t t, bit drain = 1'b0);
    pend_t p;
    p.t = t;
    p.drain_first = drain;
    pending_q.push_back(p);
  endtask

  task automatic report(string what, int got, int want);
    n_errors++;
    $display("mismatch at result %0d: %s got %0d want %0d", n_seen, what, got, want);
  endtask

  function automatic int pick_gap();
    int k;
    k = $urandom_range(0, 99);
    if (k < 50) return 0;
    if (k < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 300);
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb: failure");
      $finish;
    end
  end

  // input acceptance and prediction
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      format_q.push_back(classify(timing_t'(s_axis_tdata[70:0])));
      n_taken++;
    end
  end

  // result check
  always @(posedge clk_i) begin
    format_t got;
    format_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = format_t'(m_axis_tdata[45:0]);
      if (format_q.size() == 0) begin
        n_errors++;
        $display("unexpected result item %0d", n_seen);
      end else begin
        want = format_q.pop_front();
        if (got.status != want.status)
          report("status", int'(got.status), int'(want.status));
        if (got.fmt != want.fmt) report("format_code", int'(got.fmt), int'(want.fmt));
        if (got.ok != want.ok) report("valid_res", int'(got.ok), int'(want.ok));
        if (got.rate != want.rate) report("frame_rate", int'(got.rate), int'(want.rate));
        if (got.intl != want.intl) report("interlaced", int'(got.intl), int'(want.intl));
        if (got.idx != want.idx) report("entry_index", int'(got.idx), int'(want.idx));
        if (got.height != want.height)
          report("height", int'(got.height), int'(want.height));
        if (got.width != want.width) report("width", int'(got.width), int'(want.width));
        if (want.status == vtc_pkg::StMatched) n_match++;
        if (want.status == vtc_pkg::StFallback) n_fallback++;
        if (!want.ok) n_reject++;
      end
      n_seen++;
    end
  end

  // sender
  always @(negedge clk_i) begin
    if (rst_ni && !(s_axis_tvalid && n_taken != n_sent)) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pending_q.size() != 0 &&
                   !(pending_q[0].drain_first && format_q.size() != 0)) begin
        s_axis_tdata <= {1'b0, pending_q[0].t};
        pending_q.pop_front();
        s_axis_tvalid <= 1'b1;
        n_sent++;
        in_gap <= (n_sent > 300 && n_sent < 400) ? 0 : pick_gap();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver; one long hold-off while the sender keeps offering items
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!stall_done && n_seen == 200) begin
        stall_done <= 1'b1;
        long_hold <= 2000;
        m_axis_tready <= 1'b0;
      end else if (long_hold > 0) begin
        long_hold <= long_hold - 1;
        m_axis_tready <= (long_hold == 1);
      end else if (n_seen > 500 && n_seen < 600) begin
        m_axis_tready <= 1'b1;
      end else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        out_gap <= pick_gap();
      end
    end
  end

  initial begin
    timing_t t;
    int      k;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: extremes and special cases
    t = row_timing(0); t.on = 1'b0; queue_item(t);
    t = '1; queue_item(t);
    t = row_timing(3); t.cnt = 8'd0; queue_item(t);
    t = row_timing(3); t.ht = 14'd0; queue_item(t);
    t = row_timing(3); t.vt = 12'd0; queue_item(t);
    t = '1; t.ht = 14'd5; t.vic = 8'd0; queue_item(t);
    t = '1; t.ht = 14'd5; t.vic = 8'd1; queue_item(t);
    t = '1; t.ht = 14'd5; t.vic = 8'd64; queue_item(t);
    t = '1; t.ht = 14'd5; t.vic = 8'd65; queue_item(t);
    t = '1; t.ht = 14'd5; t.vic = 8'd255; t.mode = 2'd3; queue_item(t);
    t = row_timing(55); t.cnt = 8'd1; t.vt = 12'd525; queue_item(t);
    t = row_timing(57); t.cnt = 8'd1; t.vt = 12'd263; queue_item(t);
    t = row_timing(31); t.cnt = 8'd4; queue_item(t);
    t = row_timing(63); t.cnt = 8'd255; t.mode = 2'd0; queue_item(t);
    t = row_timing(47); t.cnt = 8'd2; t.mode = 2'd1; queue_item(t);
    t = row_timing(16); t.cnt = 8'd10; t.mode = 2'd2; queue_item(t);
    t = '0; t.on = 1'b1; t.cnt = 8'd1; t.ht = 14'd1; t.vt = 12'd1; queue_item(t, 1'b1);

    for (int n = 0; n < RandItems; n++) begin
      k = $urandom_range(0, 9);
      if (k < 7) t = row_timing($urandom_range(0, 63));
      else t = noise_timing();
      if (k == 7) t.vic = 8'($urandom_range(0, 70));
      queue_item(t, n == 600);
    end

    feeding = 1'b1;
    while (pending_q.size() != 0 || n_taken != n_sent || format_q.size() != 0)
      @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    $display("covered %0d items: %0d table matches, %0d VIC fallbacks, %0d rejected",
             n_seen, n_match, n_fallback, n_reject);
    $display("with random gaps on both sides, one long output hold-off and a drained pause");
    if (n_errors == 0 && format_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
